// ===== hdl/wpfc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpfc_pkg
// shared widths, constants and register codes of the windowed pid force control
// ----------------------------------------------------------------------------
package wpfc_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int ERR_W     = 11;
	localparam int DIFF_W    = 12;
	localparam int GAIN_W    = 16;
	localparam int DRIVE_W   = 8;
	localparam int FRAC_BITS = 12;
	localparam int S_DATA_W  = 16;
	localparam int CFG_IDX_W = 2;

	localparam int DRIVE_MIN = -90;
	localparam int DRIVE_MAX = 90;

	localparam logic signed [GAIN_W-1:0] GAIN_PROP_RST  = 16'sd1720;
	localparam logic signed [GAIN_W-1:0] GAIN_INTEG_RST = 16'sd0;
	localparam logic signed [GAIN_W-1:0] GAIN_DERIV_RST = 16'sd0;
	localparam logic [SAMPLE_W-1:0]      SETPOINT_RST   = 10'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_PROP  = 2'd0,
		REG_GAIN_INTEG = 2'd1,
		REG_GAIN_DERIV = 2'd2,
		REG_SETPOINT   = 2'd3
	} reg_index_t;

endpackage

// ===== hdl/wpfc_ring.sv =====
// ----------------------------------------------------------------------------
// wpfc_ring
// error window: ring memory, running window sum and previous error
// ----------------------------------------------------------------------------
module wpfc_ring
	import wpfc_pkg::*;
#(
	parameter int WINDOW = 16,
	parameter int SUM_W  = ERR_W + $clog2(WINDOW)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  logic signed [ERR_W-1:0] err,
	output logic signed [ERR_W-1:0] err_prev,
	output logic signed [SUM_W-1:0] sum_next
);

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW - 1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	logic signed [ERR_W-1:0] mem [WINDOW];
	logic signed [ERR_W-1:0] oldest_q;
	logic signed [ERR_W-1:0] oldest;
	logic signed [ERR_W-1:0] prev_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [PTR_W-1:0]        ptr_q;
	logic [PTR_W-1:0]        ptr_next;
	logic [PTR_W-1:0]        ptr_ahead;
	logic                    full_q;

	assign ptr_next  = ptr_inc(ptr_q);
	assign ptr_ahead = ptr_inc(ptr_next);

	// slots not yet written since reset read as zero
	assign oldest   = full_q ? oldest_q : '0;
	assign sum_next = sum_q + SUM_W'(err) - SUM_W'(oldest);
	assign err_prev = prev_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[ptr_next] <= err;
			oldest_q      <= mem[ptr_ahead];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q  <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
			prev_q <= '0;
		end else if (push) begin
			ptr_q  <= ptr_next;
			sum_q  <= sum_next;
			prev_q <= err;
			if (ptr_next == '0) begin
				full_q <= 1'b1;
			end
		end
	end

endmodule

// ===== hdl/windowed_pid_force_control.sv =====
// ----------------------------------------------------------------------------
// windowed_pid_force_control
// pid force loop with a moving-window integral and a saturated screw drive
// ----------------------------------------------------------------------------
// usage:
//   s_* carries force samples, one per beat; m_* returns one screw drive value
//   per sample, in order. gains and setpoint are written through wr_en,
//   wr_index and wr_data; the user must do so only while no sample is in flight;
//   the block does not enforce it. a sample is taken whenever s_tvalid and
//   s_tready are high, one per cycle. the ring update and error terms are
//   registered at the accepting edge, then the three gain products, then the
//   sum, the shift and the saturation into the output register with m_tvalid.
//   throughput is one beat per cycle while the output is not stalled; each stage
//   holds one sample and moves on when the stage after it is empty or moving.
//   if the receiver stalls, the output holds and the pipeline fills behind it;
//   s_tready drops once all three stages are occupied.
//   reset clears the gains to their defaults, the setpoint to one, the window
//   sum and the previous error to zero; ring slots read as zero until the
//   ring has been written once all the way round, so no clearing pass runs.
// ----------------------------------------------------------------------------
module windowed_pid_force_control
	import wpfc_pkg::*;
#(
	parameter int WINDOW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,   // force_sample[9:0], zero fill
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DRIVE_W-1:0]   m_tdata,   // screw_drive[7:0]
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [GAIN_W-1:0]    wr_data
);

	localparam int SUM_W = ERR_W + $clog2(WINDOW);
	localparam int PP_W  = ERR_W + GAIN_W;
	localparam int PI_W  = SUM_W + GAIN_W;
	localparam int PD_W  = DIFF_W + GAIN_W;
	localparam int TOT_W = ((PI_W > PD_W) ? PI_W : PD_W) + 2;

	logic signed [GAIN_W-1:0] gain_prop_q;
	logic signed [GAIN_W-1:0] gain_integ_q;
	logic signed [GAIN_W-1:0] gain_deriv_q;
	logic [SAMPLE_W-1:0]      setpoint_q;

	logic                     accept;
	logic                     adv1, adv2, adv3;
	logic                     v1_q, v2_q;
	logic signed [ERR_W-1:0]  err;
	logic signed [ERR_W-1:0]  err_prev;
	logic signed [SUM_W-1:0]  sum_next;

	logic signed [ERR_W-1:0]  err_s1;
	logic signed [DIFF_W-1:0] diff_s1;
	logic signed [SUM_W-1:0]  sum_s1;

	logic signed [PP_W-1:0]   prod_p_s2;
	logic signed [PI_W-1:0]   prod_i_s2;
	logic signed [PD_W-1:0]   prod_d_s2;

	logic signed [TOT_W-1:0]  total;
	logic signed [TOT_W-1:0]  shifted;
	logic signed [DRIVE_W-1:0] drive;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= GAIN_PROP_RST;
			gain_integ_q <= GAIN_INTEG_RST;
			gain_deriv_q <= GAIN_DERIV_RST;
			setpoint_q   <= SETPOINT_RST;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_GAIN_PROP:  gain_prop_q  <= wr_data;
				REG_GAIN_INTEG: gain_integ_q <= wr_data;
				REG_GAIN_DERIV: gain_deriv_q <= wr_data;
				REG_SETPOINT:   setpoint_q   <= wr_data[SAMPLE_W-1:0];
			endcase
		end
	end

	assign adv3     = !m_tvalid || m_tready;
	assign adv2     = !v2_q || adv3;
	assign adv1     = !v1_q || adv2;
	assign s_tready = adv1;
	assign accept   = s_tvalid && s_tready;

	assign err = $signed({1'b0, setpoint_q}) - $signed({1'b0, s_tdata[SAMPLE_W-1:0]});

	wpfc_ring #(
		.WINDOW (WINDOW),
		.SUM_W  (SUM_W)
	) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.err      (err),
		.err_prev (err_prev),
		.sum_next (sum_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv1) begin
				v1_q <= accept;
			end
			if (adv2) begin
				v2_q <= v1_q;
			end
			if (adv3) begin
				m_tvalid <= v2_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			err_s1  <= err;
			diff_s1 <= DIFF_W'(err) - DIFF_W'(err_prev);
			sum_s1  <= sum_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && v1_q) begin
			prod_p_s2 <= PP_W'(err_s1) * PP_W'(gain_prop_q);
			prod_i_s2 <= PI_W'(sum_s1) * PI_W'(gain_integ_q);
			prod_d_s2 <= PD_W'(diff_s1) * PD_W'(gain_deriv_q);
		end
	end

	// arithmetic shift rounds toward minus infinity
	assign total   = TOT_W'(prod_p_s2) + TOT_W'(prod_i_s2) - TOT_W'(prod_d_s2);
	assign shifted = total >>> FRAC_BITS;

	always_comb begin
		priority if (shifted < TOT_W'(DRIVE_MIN)) begin
			drive = DRIVE_W'(DRIVE_MIN);
		end else if (shifted > TOT_W'(DRIVE_MAX)) begin
			drive = DRIVE_W'(DRIVE_MAX);
		end else begin
			drive = DRIVE_W'(shifted);
		end
	end

	always_ff @(posedge clk) begin
		if (adv3 && v2_q) begin
			m_tdata <= drive;
		end
	end

endmodule

// ===== hdl/wpfc_checker.sv =====
// ----------------------------------------------------------------------------
// wpfc_checker
// port-level checks of the windowed pid force control, bound to the top level
// ----------------------------------------------------------------------------
module wpfc_checker
	import wpfc_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [DRIVE_W-1:0] m_tdata
);

	logic [2:0] inflight_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = s_tvalid && s_tready;
	assign out_beat = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_beat) - 3'(out_beat);
		end
	end

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) >= DRIVE_W'(DRIVE_MIN))
			&& ($signed(m_tdata) <= DRIVE_W'(DRIVE_MAX)))
		else $error("screw drive outside saturation range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled output beat changed");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat |-> (inflight_q != 3'd0))
		else $error("output beat without a sample in flight");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd3)
		else $error("more samples in flight than pipeline stages");

endmodule

bind windowed_pid_force_control wpfc_checker u_wpfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
